[rtl/mgme_pkg.sv]
// ----------------------------------------------------------------------------
// mgme_pkg
// Shared types and constants of the multicast group membership engine.
// ----------------------------------------------------------------------------
package mgme_pkg;

	localparam int GROUPS_DEF     = 16;
	localparam int INTERFACES_DEF = 4;

	localparam logic [31:0] ALL_SYSTEMS = 32'hE000_0001;

	localparam logic [2:0] ACT_JOIN   = 3'd0;
	localparam logic [2:0] ACT_LEAVE  = 3'd1;
	localparam logic [2:0] ACT_QUERY  = 3'd2;
	localparam logic [2:0] ACT_REPORT = 3'd3;
	localparam logic [2:0] ACT_TICK   = 3'd4;
	localparam logic [2:0] ACT_OTHER  = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_LEAVE  = 2'd2;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_BAD        = 3'd1;
	localparam logic [2:0] STS_FULL       = 3'd2;
	localparam logic [2:0] STS_BAD_FRAME  = 3'd3;
	localparam logic [2:0] STS_NOT_US     = 3'd4;
	localparam logic [2:0] STS_UNEXPECTED = 3'd5;

	localparam logic CFG_JOIN_DELAY = 1'b0;
	localparam logic CFG_V1_MAXRESP = 1'b1;

	localparam logic [7:0] JOIN_DELAY_RST = 8'd5;
	localparam logic [7:0] V1_MAXRESP_RST = 8'd10;

	typedef enum logic [1:0] {GS_NON, GS_IDLE, GS_DELAY} gstate_t;

	typedef enum logic [3:0] {
		OP_JOIN, OP_LEAVE, OP_QGEN, OP_QALL, OP_QGRP,
		OP_REPORT, OP_OTHER, OP_TICK, OP_STATUS
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  ifc;
		logic [31:0] addr;
		logic [31:0] mgrp;
		logic [7:0]  mr;
		logic [2:0]  status;
	} item_t;

	typedef struct packed {
		logic [1:0]  ifc;
		logic [31:0] addr;
		gstate_t     st;
		logic [7:0]  timer;
		logic        flag;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE, S_FIND_RD, S_FIND_EV, S_APPLY, S_WALK_RD, S_WALK_EV, S_DONE
	} bstate_t;

endpackage

[rtl/mgme_front.sv]
// ----------------------------------------------------------------------------
// mgme_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mgme_front #(
	parameter int INTERFACES = mgme_pkg::INTERFACES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          action,
	input  logic [1:0]          interface_id,
	input  logic [31:0]         target_address,
	input  logic [31:0]         message_group,
	input  logic [7:0]          max_response,
	input  logic                frame_valid,
	input  logic [7:0]          v1_max_resp,
	output logic                q_valid,
	output mgme_pkg::item_t     q_item,
	input  logic                q_pop
);

	mgme_pkg::item_t it;
	mgme_pkg::item_t fifo_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push;

	always_comb begin
		it        = '0;
		it.op     = mgme_pkg::OP_STATUS;
		it.ifc    = interface_id;
		it.addr   = target_address;
		it.mgrp   = message_group;
		it.mr     = max_response;
		it.status = mgme_pkg::STS_OK;
		case (action)
			mgme_pkg::ACT_JOIN: begin
				if (target_address[31:28] != 4'hE || 32'(interface_id) >= INTERFACES)
					it.status = mgme_pkg::STS_BAD;
				else
					it.op = mgme_pkg::OP_JOIN;
			end
			mgme_pkg::ACT_LEAVE: it.op = mgme_pkg::OP_LEAVE;
			mgme_pkg::ACT_TICK:  it.op = mgme_pkg::OP_TICK;
			mgme_pkg::ACT_QUERY, mgme_pkg::ACT_REPORT, mgme_pkg::ACT_OTHER: begin
				if (!frame_valid) begin
					it.status = mgme_pkg::STS_BAD_FRAME;
				end else if (action == mgme_pkg::ACT_REPORT) begin
					it.op = mgme_pkg::OP_REPORT;
				end else if (action == mgme_pkg::ACT_OTHER) begin
					it.op = mgme_pkg::OP_OTHER;
				end else if (target_address == mgme_pkg::ALL_SYSTEMS && message_group == '0) begin
					it.op = mgme_pkg::OP_QGEN;
					it.mr = (max_response == '0) ? v1_max_resp : max_response;
				end else if (target_address == mgme_pkg::ALL_SYSTEMS) begin
					it.op = mgme_pkg::OP_QALL;
				end else begin
					it.op = mgme_pkg::OP_QGRP;
				end
			end
			default: it.status = mgme_pkg::STS_BAD;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= it;
	end

endmodule

[rtl/mgme_back.sv]
// ----------------------------------------------------------------------------
// mgme_back
// Walks the group table for queued transactions as needed and issues results.
// ----------------------------------------------------------------------------
module mgme_back #(
	parameter int GROUPS     = mgme_pkg::GROUPS_DEF,
	parameter int INTERFACES = mgme_pkg::INTERFACES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mgme_pkg::item_t q_item,
	output logic            q_pop,
	input  logic [7:0]      join_delay,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      kind,
	output logic [1:0]      out_interface,
	output logic [31:0]     out_group,
	output logic [2:0]      status,
	output logic            last
);

	localparam int IW    = $clog2(GROUPS);
	localparam int UW    = $clog2(GROUPS + 1);
	localparam int NINIT = (INTERFACES < GROUPS) ? INTERFACES : GROUPS;

	mgme_pkg::bstate_t state_q, state_d;
	mgme_pkg::item_t   it_q, it_d;
	mgme_pkg::entry_t  ent_q, ent_d, ent_rd, ne;
	mgme_pkg::entry_t  mem_q [GROUPS];
	mgme_pkg::entry_t  rd_s;
	mgme_pkg::entry_t  wdata;
	logic [31:0]       key_q, key_d;
	logic              sec_q, sec_d, found_q, found_d;
	logic [IW-1:0]     cnt_q, cnt_d, g_q, g_d, waddr, top_idx;
	logic [UW-1:0]     used_q, used_d;
	logic [2:0]        sts_q, sts_d;
	logic [NINIT-1:0]  init_q;
	logic              we, ld, emit, adv;
	logic [1:0]        e_kind, e_ifc;
	logic [31:0]       e_grp;
	logic [2:0]        e_sts;
	logic              e_last;

	function automatic mgme_pkg::entry_t query_entry(mgme_pkg::entry_t e, logic [7:0] mr);
		mgme_pkg::entry_t r;
		r = e;
		if (e.st == mgme_pkg::GS_IDLE || (e.st == mgme_pkg::GS_DELAY && mr > e.timer)) begin
			r.timer = {1'b0, mr[7:1]};
			r.st    = mgme_pkg::GS_DELAY;
		end
		return r;
	endfunction

	always_comb begin
		ent_rd = rd_s;
		for (int k = 0; k < NINIT; k++) begin
			if (cnt_q == IW'(k) && !init_q[k]) begin
				ent_rd.ifc   = 2'(k);
				ent_rd.addr  = mgme_pkg::ALL_SYSTEMS;
				ent_rd.st    = mgme_pkg::GS_IDLE;
				ent_rd.timer = '0;
				ent_rd.flag  = 1'b0;
			end
		end
	end

	assign ld      = !out_valid || !out_stall;
	assign top_idx = IW'(used_q - UW'(1));

	always_comb begin
		state_d = state_q;
		it_d    = it_q;
		ent_d   = ent_q;
		key_d   = key_q;
		sec_d   = sec_q;
		found_d = found_q;
		cnt_d   = cnt_q;
		g_d     = g_q;
		used_d  = used_q;
		sts_d   = sts_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		waddr   = cnt_q;
		wdata   = ent_rd;
		ne      = ent_rd;
		adv     = 1'b1;
		emit    = 1'b0;
		e_kind  = mgme_pkg::KIND_REPORT;
		e_ifc   = it_q.ifc;
		e_grp   = it_q.addr;
		e_sts   = mgme_pkg::STS_OK;
		e_last  = 1'b0;
		case (state_q)
			mgme_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					it_d  = q_item;
					key_d = q_item.addr;
					sec_d = 1'b0;
					cnt_d = top_idx;
					sts_d = q_item.status;
					case (q_item.op)
						mgme_pkg::OP_STATUS: state_d = mgme_pkg::S_DONE;
						mgme_pkg::OP_TICK:   state_d = mgme_pkg::S_WALK_RD;
						default:             state_d = mgme_pkg::S_FIND_RD;
					endcase
				end
			end
			mgme_pkg::S_FIND_RD: state_d = mgme_pkg::S_FIND_EV;
			mgme_pkg::S_FIND_EV: begin
				if (ent_rd.ifc == it_q.ifc && ent_rd.addr == key_q) begin
					found_d = 1'b1;
					ent_d   = ent_rd;
					g_d     = cnt_q;
					state_d = mgme_pkg::S_APPLY;
				end else if (cnt_q == '0) begin
					found_d = 1'b0;
					state_d = mgme_pkg::S_APPLY;
				end else begin
					cnt_d   = cnt_q - IW'(1);
					state_d = mgme_pkg::S_FIND_RD;
				end
			end
			mgme_pkg::S_APPLY: begin
				waddr = g_q;
				wdata = ent_q;
				case (it_q.op)
					mgme_pkg::OP_JOIN: begin
						wdata.ifc   = it_q.ifc;
						wdata.addr  = it_q.addr;
						wdata.st    = mgme_pkg::GS_DELAY;
						wdata.timer = join_delay;
						wdata.flag  = 1'b1;
						if (found_q) begin
							if (ent_q.st != mgme_pkg::GS_NON) begin
								state_d = mgme_pkg::S_DONE;
							end else if (ld) begin
								emit    = 1'b1;
								we      = 1'b1;
								state_d = mgme_pkg::S_DONE;
							end
						end else if (32'(used_q) >= GROUPS) begin
							sts_d   = mgme_pkg::STS_FULL;
							state_d = mgme_pkg::S_DONE;
						end else if (ld) begin
							emit    = 1'b1;
							we      = 1'b1;
							waddr   = IW'(used_q);
							used_d  = used_q + UW'(1);
							state_d = mgme_pkg::S_DONE;
						end
					end
					mgme_pkg::OP_LEAVE: begin
						wdata.st    = mgme_pkg::GS_NON;
						wdata.timer = '0;
						wdata.flag  = 1'b0;
						e_kind      = mgme_pkg::KIND_LEAVE;
						if (!found_q) begin
							sts_d   = mgme_pkg::STS_BAD;
							state_d = mgme_pkg::S_DONE;
						end else if (!ent_q.flag || ld) begin
							emit    = ent_q.flag;
							we      = 1'b1;
							state_d = mgme_pkg::S_DONE;
						end
					end
					mgme_pkg::OP_QGEN: begin
						if (!found_q) begin
							sts_d   = mgme_pkg::STS_NOT_US;
							state_d = mgme_pkg::S_DONE;
						end else begin
							cnt_d   = top_idx;
							state_d = mgme_pkg::S_WALK_RD;
						end
					end
					mgme_pkg::OP_QALL: begin
						state_d = mgme_pkg::S_DONE;
						if (!found_q) begin
							if (!sec_q)
								sts_d = mgme_pkg::STS_NOT_US;
						end else if (sec_q) begin
							we    = 1'b1;
							wdata = query_entry(ent_q, it_q.mr);
						end else begin
							sec_d   = 1'b1;
							key_d   = it_q.mgrp;
							cnt_d   = top_idx;
							state_d = mgme_pkg::S_FIND_RD;
						end
					end
					mgme_pkg::OP_QGRP: begin
						state_d = mgme_pkg::S_DONE;
						if (!found_q) begin
							sts_d = mgme_pkg::STS_NOT_US;
						end else begin
							we    = 1'b1;
							wdata = query_entry(ent_q, it_q.mr);
						end
					end
					mgme_pkg::OP_REPORT: begin
						state_d = mgme_pkg::S_DONE;
						wdata.st    = mgme_pkg::GS_IDLE;
						wdata.timer = '0;
						wdata.flag  = 1'b0;
						if (!found_q)
							sts_d = mgme_pkg::STS_NOT_US;
						else
							we = (ent_q.st == mgme_pkg::GS_DELAY);
					end
					mgme_pkg::OP_OTHER: begin
						state_d = mgme_pkg::S_DONE;
						sts_d   = found_q ? mgme_pkg::STS_UNEXPECTED : mgme_pkg::STS_NOT_US;
					end
					default: state_d = mgme_pkg::S_DONE;
				endcase
			end
			mgme_pkg::S_WALK_RD: state_d = mgme_pkg::S_WALK_EV;
			mgme_pkg::S_WALK_EV: begin
				e_ifc = ent_rd.ifc;
				e_grp = ent_rd.addr;
				if (it_q.op == mgme_pkg::OP_TICK) begin
					if (ent_rd.timer != '0) begin
						ne.timer = ent_rd.timer - 8'd1;
						if (ne.timer == '0 && ent_rd.st == mgme_pkg::GS_DELAY) begin
							ne.flag = 1'b1;
							adv     = ld;
							emit    = ld;
						end
						we    = adv;
						wdata = ne;
					end
				end else if (ent_rd.ifc == it_q.ifc && ent_rd.addr != mgme_pkg::ALL_SYSTEMS) begin
					we    = 1'b1;
					wdata = query_entry(ent_rd, it_q.mr);
				end
				if (adv) begin
					if (cnt_q == '0) begin
						state_d = mgme_pkg::S_DONE;
					end else begin
						cnt_d   = cnt_q - IW'(1);
						state_d = mgme_pkg::S_WALK_RD;
					end
				end
			end
			mgme_pkg::S_DONE: begin
				e_kind = mgme_pkg::KIND_STATUS;
				e_ifc  = '0;
				e_grp  = '0;
				e_sts  = sts_q;
				e_last = 1'b1;
				if (ld) begin
					emit    = 1'b1;
					state_d = mgme_pkg::S_IDLE;
				end
			end
			default: state_d = mgme_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mgme_pkg::S_IDLE;
			used_q    <= UW'(NINIT);
			init_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (ld)
				out_valid <= emit;
			if (we) begin
				for (int k = 0; k < NINIT; k++) begin
					if (waddr == IW'(k))
						init_q[k] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		it_q    <= it_d;
		ent_q   <= ent_d;
		key_q   <= key_d;
		sec_q   <= sec_d;
		found_q <= found_d;
		cnt_q   <= cnt_d;
		g_q     <= g_d;
		sts_q   <= sts_d;
		if (ld && emit) begin
			kind          <= e_kind;
			out_interface <= e_ifc;
			out_group     <= e_grp;
			status        <= e_sts;
			last          <= e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_s <= mem_q[cnt_q];
	end

endmodule

[rtl/multicast_group_membership_engine_core.sv]
// ----------------------------------------------------------------------------
// multicast_group_membership_engine_core
// Host-side group membership engine with a table of joined groups.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one transaction per item: join,
// leave, received query, received report, other message, or tick. The
// front end classifies it and holds up to two items in a queue; in_stall
// rises only when that queue is full.
// The back end processes one item at a time. A table search visits
// entries newest first, a memory read then a compare for each; a tick or
// general query walks all used entries. A query on all-systems naming a
// group runs two searches. After the closing status is issued the back end
// returns to idle and takes the next item.
// Output channel (out_valid/out_stall) carries zero or more report or leave
// transactions followed by one status transaction with last set. The output
// register holds while out_stall is high, and the back end waits whenever it has a transaction to issue.
// Reset puts one all-systems entry per interface in the idle state, with
// both configuration registers at their defaults; no clearing pass is run.
// Configuration writes (cfg_we) update the registers; queued items keep the V1 max response set at classification.
// ----------------------------------------------------------------------------
module multicast_group_membership_engine_core #(
	parameter int GROUPS     = mgme_pkg::GROUPS_DEF,
	parameter int INTERFACES = mgme_pkg::INTERFACES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [1:0]  interface_id,
	input  logic [31:0] target_address,
	input  logic [31:0] message_group,
	input  logic [7:0]  max_response,
	input  logic        frame_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  out_interface,
	output logic [31:0] out_group,
	output logic [2:0]  status,
	output logic        last
);

	logic [7:0]      join_delay_q, v1_max_resp_q;
	logic            q_valid, q_pop;
	mgme_pkg::item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_delay_q  <= mgme_pkg::JOIN_DELAY_RST;
			v1_max_resp_q <= mgme_pkg::V1_MAXRESP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mgme_pkg::CFG_JOIN_DELAY: join_delay_q  <= cfg_data;
				mgme_pkg::CFG_V1_MAXRESP: v1_max_resp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mgme_front #(
		.INTERFACES(INTERFACES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.interface_id   (interface_id),
		.target_address (target_address),
		.message_group  (message_group),
		.max_response   (max_response),
		.frame_valid    (frame_valid),
		.v1_max_resp    (v1_max_resp_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	mgme_back #(
		.GROUPS     (GROUPS),
		.INTERFACES (INTERFACES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.join_delay    (join_delay_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_interface (out_interface),
		.out_group     (out_group),
		.status        (status),
		.last          (last)
	);

	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == mgme_pkg::KIND_STATUS && out_interface == 2'd0
			&& out_group == 32'd0)
		else $error("closing item carries a message");

	a_message_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (kind == mgme_pkg::KIND_REPORT || kind == mgme_pkg::KIND_LEAVE)
			&& status == mgme_pkg::STS_OK)
		else $error("message item malformed");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
